[sv/fcr_pkg.sv]
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants of the frame command receiver: phase codes, frame
// patterns, device codes and the switch read response frame.
// ----------------------------------------------------------------------------
package fcr_pkg;

   // receiver phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_TRAILER = 3'b100
   } phase_type;

   // largest payload that is read; larger sizes go straight to the trailer
   localparam logic [15:0] PAYLOAD_LIMIT = 16'd64;
   // number of LEDs that commands may address (1 to 4)
   localparam int unsigned LED_COUNT = 4;

   localparam logic [2:0] HEADER_PATTERN  = 3'b101;
   localparam logic [2:0] TRAILER_PATTERN = 3'b010;
   localparam logic [7:0] DEV_SWITCH_READ = 8'h04;
   localparam logic [2:0] COLOR_MASK      = 3'b111;

   // switch read response: A1 00 00 04 sw 41
   localparam logic [7:0] RSP_HEADER_0 = 8'hA1;
   localparam logic [7:0] RSP_HEADER_1 = 8'h00;
   localparam logic [7:0] RSP_HEADER_2 = 8'h00;
   localparam logic [7:0] RSP_HEADER_3 = DEV_SWITCH_READ;
   localparam logic [7:0] RSP_TRAILER  = 8'h41;

   // response burst positions
   localparam logic [2:0] BURST_SWITCHES = 3'd4;
   localparam logic [2:0] BURST_LAST     = 3'd5;

endpackage

[sv/frame_command_receiver.sv]
// ----------------------------------------------------------------------------
// frame_command_receiver
// Byte-serial command frame receiver: deframes headers, payloads and
// trailers, drives the LED register and answers switch read commands.
// ----------------------------------------------------------------------------
// The receiver takes one byte per cycle. The frame state is updated in the
// cycle a byte is transferred, and any results it causes are loaded into a
// result register. A byte that completes nothing gives no result; a valid
// LED command gives one transfer, a valid switch read gives a burst of six
// (A1 00 00 04 sw 41). While a burst is in the result register, new bytes
// are taken only in the cycle its last transfer leaves, so a switch read
// holds the input until that transfer leaves; otherwise a byte is taken every cycle.
module frame_command_receiver
   import fcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // rx_byte[7:0], switches[11:8], zero[15:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // tx_byte[7:0], led_bits[19:8], zero[23:20]
   output logic [1:0]  rsp_tuser,   // tx_valid[0], led_write[1]
   output logic        rsp_tlast
);

   // frame state
   phase_type   phase_ff,       phase_in;
   logic [1:0]  hdr_idx_ff,     hdr_idx_in;
   logic        hdr_ok_ff,      hdr_ok_in;
   logic        long_ff,        long_in;
   logic [15:0] size_ff,        size_in;
   logic [7:0]  device_ff,      device_in;
   logic [15:0] left_ff,        left_in;
   logic [7:0]  first_ff,       first_in;
   logic        read_ff,        read_in;
   logic [11:0] led_ff,         led_in;

   // result burst register
   logic        burst_valid_ff, burst_valid_in;
   logic        burst_sw_ff,    burst_sw_in;
   logic [2:0]  burst_idx_ff,   burst_idx_in;
   logic [3:0]  burst_swv_ff,   burst_swv_in;
   logic [11:0] burst_led_ff,   burst_led_in;

   logic        in_fire, out_fire, burst_end;
   logic [7:0]  rx_byte;
   logic [3:0]  switches;
   logic [15:0] left_dec;
   logic        trailer_ok, cmd_led, cmd_sw;
   logic [2:0]  color;
   logic [7:0]  tx_byte;
   logic        tx_valid, led_write, out_last;

   assign rx_byte  = req_tdata[7:0];
   assign switches = req_tdata[11:8];
   assign left_dec = left_ff - 16'd1;

   assign trailer_ok = (rx_byte[7:5] == TRAILER_PATTERN) && (rx_byte[4] == long_ff) &&
                       (long_ff || (rx_byte[3:0] == size_ff[3:0]));
   assign cmd_led = trailer_ok && (device_ff < 8'(LED_COUNT));
   assign cmd_sw  = trailer_ok && (device_ff == DEV_SWITCH_READ);
   assign color   = read_ff ? (first_ff[2:0] & COLOR_MASK) : 3'd0;

   assign out_last  = !burst_sw_ff || (burst_idx_ff == BURST_LAST);
   assign out_fire  = rsp_tvalid && rsp_tready;
   assign burst_end = out_fire && out_last;
   assign req_tready = !burst_valid_ff || burst_end;
   assign in_fire    = req_tvalid && req_tready;

   // frame state update for one received byte
   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      hdr_ok_in  = hdr_ok_ff;
      long_in    = long_ff;
      size_in    = size_ff;
      device_in  = device_ff;
      left_in    = left_ff;
      first_in   = first_ff;
      read_in    = read_ff;
      led_in     = led_ff;
      if (in_fire) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               if (!read_ff) begin
                  first_in = rx_byte;
                  read_in  = 1'b1;
               end
               left_in = left_dec;
               if (left_dec == 16'd0) begin
                  phase_in = PH_TRAILER;
               end
            end
            PH_TRAILER: begin
               phase_in   = PH_HEADER;
               hdr_idx_in = 2'd0;
               if (cmd_led) begin
                  for (int i = 0; i < LED_COUNT; i++) begin
                     if (device_ff[1:0] == 2'(i)) begin
                        led_in[3*i +: 3] = color;
                     end
                  end
               end
            end
            default: begin
               phase_in = PH_HEADER;
               case (hdr_idx_ff)
                  2'd0: begin
                     hdr_ok_in  = (rx_byte[7:5] == HEADER_PATTERN);
                     long_in    = rx_byte[4];
                     size_in    = {12'd0, rx_byte[3:0]};
                     hdr_idx_in = 2'd1;
                  end
                  2'd1: begin
                     if (long_ff) begin
                        size_in = {rx_byte, 8'd0};
                     end
                     hdr_idx_in = 2'd2;
                  end
                  2'd2: begin
                     if (long_ff) begin
                        size_in = {size_ff[15:8], rx_byte};
                     end
                     hdr_idx_in = 2'd3;
                  end
                  default: begin
                     device_in  = rx_byte;
                     hdr_idx_in = 2'd0;
                     read_in    = 1'b0;
                     if (hdr_ok_ff) begin
                        if (size_ff != 16'd0 && size_ff <= PAYLOAD_LIMIT) begin
                           left_in  = size_ff;
                           phase_in = PH_PAYLOAD;
                        end else begin
                           phase_in = PH_TRAILER;
                        end
                     end
                  end
               endcase
            end
         endcase
      end
   end

   // result burst: load on a completed command, step on each transfer
   always_comb begin
      burst_valid_in = burst_valid_ff;
      burst_sw_in    = burst_sw_ff;
      burst_idx_in   = burst_idx_ff;
      burst_swv_in   = burst_swv_ff;
      burst_led_in   = burst_led_ff;
      if (burst_end) begin
         burst_valid_in = 1'b0;
      end else if (out_fire) begin
         burst_idx_in = burst_idx_ff + 3'd1;
      end
      if (in_fire && phase_ff == PH_TRAILER && (cmd_led || cmd_sw)) begin
         burst_valid_in = 1'b1;
         burst_sw_in    = cmd_sw;
         burst_idx_in   = 3'd0;
         burst_swv_in   = switches;
         burst_led_in   = led_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         hdr_idx_ff     <= 2'd0;
         hdr_ok_ff      <= 1'b0;
         long_ff        <= 1'b0;
         size_ff        <= 16'd0;
         device_ff      <= 8'd0;
         left_ff        <= 16'd0;
         first_ff       <= 8'd0;
         read_ff        <= 1'b0;
         led_ff         <= 12'd0;
         burst_valid_ff <= 1'b0;
         burst_sw_ff    <= 1'b0;
         burst_idx_ff   <= 3'd0;
      end else begin
         phase_ff       <= phase_in;
         hdr_idx_ff     <= hdr_idx_in;
         hdr_ok_ff      <= hdr_ok_in;
         long_ff        <= long_in;
         size_ff        <= size_in;
         device_ff      <= device_in;
         left_ff        <= left_in;
         first_ff       <= first_in;
         read_ff        <= read_in;
         led_ff         <= led_in;
         burst_valid_ff <= burst_valid_in;
         burst_sw_ff    <= burst_sw_in;
         burst_idx_ff   <= burst_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_swv_ff <= burst_swv_in;
      burst_led_ff <= burst_led_in;
   end

   // result fields
   always_comb begin
      tx_valid  = burst_sw_ff;
      led_write = !burst_sw_ff;
      tx_byte   = 8'd0;
      if (burst_sw_ff) begin
         case (burst_idx_ff)
            3'd0:           tx_byte = RSP_HEADER_0;
            3'd1:           tx_byte = RSP_HEADER_1;
            3'd2:           tx_byte = RSP_HEADER_2;
            3'd3:           tx_byte = RSP_HEADER_3;
            BURST_SWITCHES: tx_byte = {4'd0, burst_swv_ff};
            default:        tx_byte = RSP_TRAILER;
         endcase
      end
   end

   assign rsp_tvalid = burst_valid_ff;
   assign rsp_tdata  = {4'd0, burst_led_ff, tx_byte};
   assign rsp_tuser  = {led_write, tx_valid};
   assign rsp_tlast  = out_last;

endmodule
